// ===== hdl/fbb_pkg.sv =====
// shared types and constants for the forward box blur row core
`timescale 1ns / 1ps

package fbb_pkg;

   localparam int PIX_W = 8;
   localparam int NUM_CH = 3;
   localparam int STRENGTH_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_STRENGTH = 1'b0;

   // controller to datapath
   typedef struct packed {
      logic load;        // append the incoming pixel to the window
      logic calc;        // multiply sums by the reciprocal of the fill count
      logic emit;        // load the output word and drop the oldest pixel
      logic final_flag;  // output word closes the row
   } fbb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit_due;    // window already holds at least strength pixels before the append
      logic last_one;    // one pixel left in the window
   } fbb_sts_type;

endpackage

// ===== hdl/forward_box_blur_row_core.sv =====
// top level of the forward box blur row core
//
//  channel   direction  handshake                   word
//  req       in         req_valid / req_stall       pix_red, pix_green, pix_blue, end_of_row
//  rsp       out        rsp_valid / rsp_stall       avg_red, avg_green, avg_blue, final_out
//  csr       in/out     psel, penable, pwrite       blur_strength at byte address 0
//
//  a pixel that completes no window is only appended; one that emits passes through
//  append, reciprocal multiply and output load; an end of row holding n pixels
//  then repeats multiply and output load for each of them, on the one multiplier per channel
//  synchronous reset clears fill count, sums, state and rsp_valid; strength resets to 0
//  the output register lets the next word in while a result waits; rsp_stall
//  holds the emit step only when a new result is ready
`timescale 1ns / 1ps

module forward_box_blur_row_core
   import fbb_pkg::*;
#(
   parameter int MAX_STRENGTH = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_pix_red,
   input  logic [PIX_W-1:0]      req_pix_green,
   input  logic [PIX_W-1:0]      req_pix_blue,
   input  logic                  req_end_of_row,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_avg_red,
   output logic [PIX_W-1:0]      rsp_avg_green,
   output logic [PIX_W-1:0]      rsp_avg_blue,
   output logic                  rsp_final_out,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [STRENGTH_W-1:0] strength_ff, strength_in;
   logic                  csr_write;
   fbb_cmd_type           cmd;
   fbb_sts_type           sts;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      strength_in = strength_ff;
      if (csr_write && (paddr[2] == CSR_IDX_STRENGTH)) begin
         strength_in = pwdata[STRENGTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= '0;
      end else begin
         strength_ff <= strength_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_STRENGTH) begin
         prdata = CSR_DATA_W'(strength_ff);
      end
   end

   fbb_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_end_of_row (req_end_of_row),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .sts            (sts),
      .cmd            (cmd)
   );

   fbb_dp #(
      .MAX_STRENGTH (MAX_STRENGTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .strength  (strength_ff),
      .pix_red   (req_pix_red),
      .pix_green (req_pix_green),
      .pix_blue  (req_pix_blue),
      .avg_red   (rsp_avg_red),
      .avg_green (rsp_avg_green),
      .avg_blue  (rsp_avg_blue),
      .final_out (rsp_final_out)
   );

endmodule

// ===== hdl/fbb_ctrl.sv =====
// controller state machine for the forward box blur row core
`timescale 1ns / 1ps

module fbb_ctrl
   import fbb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_end_of_row,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  fbb_sts_type sts,
   output fbb_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       flush_ff, flush_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in        = state_ff;
      flush_in        = flush_ff;
      cmd.load        = 1'b0;
      cmd.calc        = 1'b0;
      cmd.emit        = 1'b0;
      cmd.final_flag  = flush_ff && sts.last_one;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               flush_in = req_end_of_row;
               if (req_end_of_row || sts.emit_due) begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               if (flush_ff && !sts.last_one) begin
                  state_in = ST_CALC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/fbb_dp.sv =====
// datapath: pixel window, channel sums, reciprocal multiply and output word
`timescale 1ns / 1ps

module fbb_dp
   import fbb_pkg::*;
#(
   parameter int MAX_STRENGTH = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fbb_cmd_type           cmd,
   output fbb_sts_type           sts,
   input  logic [STRENGTH_W-1:0] strength,
   input  logic [PIX_W-1:0]      pix_red,
   input  logic [PIX_W-1:0]      pix_green,
   input  logic [PIX_W-1:0]      pix_blue,
   output logic [PIX_W-1:0]      avg_red,
   output logic [PIX_W-1:0]      avg_green,
   output logic [PIX_W-1:0]      avg_blue,
   output logic                  final_out
);

   localparam int Win = MAX_STRENGTH + 1;
   localparam int FW  = $clog2(Win + 1);
   localparam int LW  = $clog2(Win);
   localparam int SW  = PIX_W + LW;
   localparam int K   = SW + LW;
   localparam int RW  = K + 1;
   localparam int PW  = SW + RW;

   logic [PIX_W-1:0] store_ff [NUM_CH][Win];
   logic [SW-1:0]    sums_ff  [NUM_CH];
   logic [SW-1:0]    sums_in  [NUM_CH];
   logic [PW-1:0]    prod_ff  [NUM_CH];
   logic [PIX_W-1:0] avg_ff   [NUM_CH];
   logic [PIX_W-1:0] pix      [NUM_CH];
   logic [FW-1:0]    fill_ff, fill_in;
   logic [RW-1:0]    recip_ff;
   logic [RW-1:0]    recip_tab [2**FW];
   logic [FW-1:0]    s_eff;
   logic             final_ff;

   // ceil(2^K / d), exact truncated quotient for sums below 2^SW
   for (genvar g = 0; g < 2**FW; g++) begin : g_recip
      localparam int Div   = (g == 0 || g > Win) ? 1 : g;
      localparam int Recip = ((2 ** K) + Div - 1) / Div;
      assign recip_tab[g] = RW'(Recip);
   end

   assign pix[0] = pix_red;
   assign pix[1] = pix_green;
   assign pix[2] = pix_blue;

   always_comb begin
      if (32'(strength) > MAX_STRENGTH) begin
         s_eff = FW'(MAX_STRENGTH);
      end else begin
         s_eff = FW'(strength);
      end
   end

   assign sts.emit_due = (fill_ff >= s_eff);
   assign sts.last_one = (fill_ff == FW'(1));

   always_comb begin
      fill_in = fill_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         sums_in[c] = sums_ff[c];
      end
      if (cmd.load) begin
         fill_in = fill_ff + FW'(1);
         for (int c = 0; c < NUM_CH; c++) begin
            sums_in[c] = sums_ff[c] + SW'(pix[c]);
         end
      end else if (cmd.emit) begin
         fill_in = fill_ff - FW'(1);
         for (int c = 0; c < NUM_CH; c++) begin
            sums_in[c] = sums_ff[c] - SW'(store_ff[c][0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int c = 0; c < NUM_CH; c++) begin
            sums_ff[c] <= '0;
         end
      end else begin
         fill_ff <= fill_in;
         for (int c = 0; c < NUM_CH; c++) begin
            sums_ff[c] <= sums_in[c];
         end
      end
   end

   // window: append at the fill point, shift toward the head on drop
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int c = 0; c < NUM_CH; c++) begin
            store_ff[c][fill_ff[LW-1:0]] <= pix[c];
         end
      end else if (cmd.emit) begin
         for (int c = 0; c < NUM_CH; c++) begin
            for (int i = 0; i < Win - 1; i++) begin
               store_ff[c][i] <= store_ff[c][i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      recip_ff <= recip_tab[fill_in];
      if (cmd.calc) begin
         for (int c = 0; c < NUM_CH; c++) begin
            prod_ff[c] <= PW'(sums_ff[c]) * PW'(recip_ff);
         end
      end
      if (cmd.emit) begin
         for (int c = 0; c < NUM_CH; c++) begin
            avg_ff[c] <= prod_ff[c][K +: PIX_W];
         end
         final_ff <= cmd.final_flag;
      end
   end

   assign avg_red   = avg_ff[0];
   assign avg_green = avg_ff[1];
   assign avg_blue  = avg_ff[2];
   assign final_out = final_ff;

endmodule

// ===== hdl/fbb_checker.sv =====
// port-level checks for the forward box blur row core, bound to the top level
`timescale 1ns / 1ps

module fbb_checker
   import fbb_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             req_end_of_row,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [PIX_W-1:0] rsp_avg_red,
   input logic [PIX_W-1:0] rsp_avg_green,
   input logic [PIX_W-1:0] rsp_avg_blue,
   input logic             rsp_final_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_avg_red) && $stable(rsp_avg_green)
         && $stable(rsp_avg_blue) && $stable(rsp_final_out))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_flush_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_row |=> req_stall)
      else $error("end of row word did not start a flush");

endmodule

bind forward_box_blur_row_core fbb_checker u_fbb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_end_of_row (req_end_of_row),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_avg_red    (rsp_avg_red),
   .rsp_avg_green  (rsp_avg_green),
   .rsp_avg_blue   (rsp_avg_blue),
   .rsp_final_out  (rsp_final_out)
);
